// ----- sv/rti_pkg.sv -----
// rti_pkg: shared widths, register indexes and pipeline types for the ray/triangle core
// no dependencies; used by rti_div, ray_triangle_intersect_core, rti_check and tb
package rti_pkg;

    // coordinate and fixed point format
    localparam int COORD_W = 32;
    localparam int FRAC_BITS = 16;
    localparam int EPS_W = 31;
    localparam int DIST_W = 31;
    localparam int CFG_W = 32;
    localparam int CFG_IDX_W = 3;

    // datapath widths
    localparam int A_W = COORD_W + 1;            // vertex minus origin
    localparam int PROD_W = 2 * A_W;             // one cross product term
    localparam int CROSS_W = PROD_W + 1;         // cross product component
    localparam int LO_W = 33;                    // low slice of a cross component
    localparam int HI_W = CROSS_W - LO_W;        // signed high slice
    localparam int TP_W = COORD_W + HI_W;        // dir times a slice
    localparam int NP_W = A_W + HI_W;            // edge vector times a slice
    localparam int DOT_W = CROSS_W + A_W + 2;    // triple product
    localparam int DEN_W = DOT_W + 1;            // sum of three triple products
    localparam int REM_W = DOT_W + FRAC_BITS;    // scaled numerator magnitude
    localparam int DIV_W = DEN_W + DIST_W;       // compare width in the divider
    localparam int DIV_STAGES = DIST_W + 1;      // saturation check plus one per bit
    localparam int FRONT_STAGES = 8;
    localparam int LATENCY = FRONT_STAGES + DIV_STAGES + 1;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(66);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5,
        REG_EPSILON  = 3'd6
    } cfg_idx_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [A_W-1:0] avec_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [CROSS_W-1:0] cross_t;
    typedef logic signed [TP_W-1:0] tpart_t;
    typedef logic signed [NP_W-1:0] npart_t;
    typedef logic signed [DOT_W-1:0] dot_t;
    typedef logic signed [DEN_W-1:0] den_t;

    // one transaction inside the long divider
    typedef struct packed {
        logic              hit;
        logic              sat;
        logic [REM_W-1:0]  rem;
        logic [DEN_W-1:0]  den;
        logic [DIST_W-1:0] quo;
    } div_stage_t;

endpackage

// ----- sv/rti_div.sv -----
// rti_div: pipelined restoring divider giving a Q15.16 distance quotient and a saturation flag
// depends on rti_pkg
module rti_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  rti_pkg::div_stage_t in_data,
    output logic               out_valid,
    output rti_pkg::div_stage_t out_data
);

    logic                vld_reg  [rti_pkg::DIV_STAGES];
    logic                vld_next [rti_pkg::DIV_STAGES];
    rti_pkg::div_stage_t stg_reg  [rti_pkg::DIV_STAGES];
    rti_pkg::div_stage_t stg_next [rti_pkg::DIV_STAGES];

    // first stage flags a quotient that does not fit, then one bit per stage
    always_comb
    begin
        vld_next[0] = in_valid;
        stg_next[0] = in_data;
        stg_next[0].sat = (rti_pkg::DIV_W'(in_data.rem)
                           >= (rti_pkg::DIV_W'(in_data.den) << rti_pkg::DIST_W));
        for (int j = 0; j < rti_pkg::DIV_STAGES - 1; j++)
        begin
            vld_next[j+1] = vld_reg[j];
            stg_next[j+1] = stg_reg[j];
            if (!stg_reg[j].sat
                && (rti_pkg::DIV_W'(stg_reg[j].rem)
                    >= (rti_pkg::DIV_W'(stg_reg[j].den) << (rti_pkg::DIST_W - 1 - j))))
            begin
                stg_next[j+1].rem = rti_pkg::REM_W'(rti_pkg::DIV_W'(stg_reg[j].rem)
                    - (rti_pkg::DIV_W'(stg_reg[j].den) << (rti_pkg::DIST_W - 1 - j)));
                stg_next[j+1].quo = stg_reg[j].quo
                    | (rti_pkg::DIST_W'(1) << (rti_pkg::DIST_W - 1 - j));
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < rti_pkg::DIV_STAGES; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
        end
        else
        begin
            for (int j = 0; j < rti_pkg::DIV_STAGES; j++)
            begin
                vld_reg[j] <= vld_next[j];
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < rti_pkg::DIV_STAGES; j++)
        begin
            stg_reg[j] <= stg_next[j];
        end
    end

    assign out_valid = vld_reg[rti_pkg::DIV_STAGES-1];
    assign out_data = stg_reg[rti_pkg::DIV_STAGES-1];

endmodule

// ----- sv/ray_triangle_intersect_core.sv -----
// ray_triangle_intersect_core: pipelined ray/triangle hit test against a configured ray
// depends on rti_pkg and rti_div
//
// One triangle is taken on every cycle that start is high; busy is always low. Each
// transaction returns hit and distance with a one-cycle done strobe, in order; the receiver
// cannot stall. Eight stages form the edge vectors from the origin, three cross products
// and four exact triple products (the numerator and the per-edge tests, whose sum is the
// normal's dot with the direction), then a 32-stage restoring divider produces t (a
// saturation check, then one quotient bit per stage for the other 31), and an output
// register holds the result.
// Ray and epsilon registers may be written only while no transaction is in flight.
module ray_triangle_intersect_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rti_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [rti_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [rti_pkg::COORD_W-1:0] a_x,
    input  logic signed [rti_pkg::COORD_W-1:0] a_y,
    input  logic signed [rti_pkg::COORD_W-1:0] a_z,
    input  logic signed [rti_pkg::COORD_W-1:0] b_x,
    input  logic signed [rti_pkg::COORD_W-1:0] b_y,
    input  logic signed [rti_pkg::COORD_W-1:0] b_z,
    input  logic signed [rti_pkg::COORD_W-1:0] c_x,
    input  logic signed [rti_pkg::COORD_W-1:0] c_y,
    input  logic signed [rti_pkg::COORD_W-1:0] c_z,
    output logic                             done,
    output logic                             hit,
    output logic [rti_pkg::DIST_W-1:0]       distance
);

    // ray registers
    rti_pkg::coord_t             org_reg [3];
    rti_pkg::coord_t             dir_reg [3];
    logic [rti_pkg::EPS_W-1:0]   eps_reg;

    // pipeline registers
    logic                        vld_reg [rti_pkg::FRONT_STAGES];
    rti_pkg::avec_t              a_reg   [3][3];
    rti_pkg::avec_t              a0_s2_reg [3];
    rti_pkg::avec_t              a0_s3_reg [3];
    rti_pkg::prod_t              pp_reg  [3][3][2];
    rti_pkg::cross_t             cr_reg  [3][3];
    rti_pkg::tpart_t             tp_reg  [3][3][2];
    rti_pkg::npart_t             np_reg  [3][2];
    rti_pkg::dot_t               tc_reg  [3][3];
    rti_pkg::dot_t               nc_reg  [3];
    rti_pkg::dot_t               t_reg   [3];
    rti_pkg::dot_t               num_reg;
    rti_pkg::den_t               den_reg;
    rti_pkg::dot_t               num_s7_reg;
    logic                        tneg_reg [3];
    logic                        tnz_reg  [3];
    rti_pkg::div_stage_t         dv_reg;
    logic                        done_reg;
    logic                        hit_reg;
    logic [rti_pkg::DIST_W-1:0]  dist_reg;

    // next values
    rti_pkg::avec_t              a_next  [3][3];
    rti_pkg::prod_t              pp_next [3][3][2];
    rti_pkg::cross_t             cr_next [3][3];
    rti_pkg::tpart_t             tp_next [3][3][2];
    rti_pkg::npart_t             np_next [3][2];
    rti_pkg::dot_t               tc_next [3][3];
    rti_pkg::dot_t               nc_next [3];
    rti_pkg::dot_t               t_next  [3];
    rti_pkg::dot_t               num_next;
    rti_pkg::den_t               den_next;
    rti_pkg::div_stage_t         dv_next;
    rti_pkg::coord_t             vtx     [3][3];
    logic                        accept;
    logic                        div_out_valid;
    rti_pkg::div_stage_t         div_out;
    logic [rti_pkg::DIST_W-1:0]  dist_next;

    assign busy = 1'b0;
    assign accept = start && !busy;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < 3; m++)
            begin
                org_reg[m] <= '0;
                dir_reg[m] <= '0;
            end
            eps_reg <= rti_pkg::EPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (rti_pkg::cfg_idx_t'(cfg_addr))
                rti_pkg::REG_ORIGIN_X: org_reg[0] <= cfg_wdata;
                rti_pkg::REG_ORIGIN_Y: org_reg[1] <= cfg_wdata;
                rti_pkg::REG_ORIGIN_Z: org_reg[2] <= cfg_wdata;
                rti_pkg::REG_DIR_X:    dir_reg[0] <= cfg_wdata;
                rti_pkg::REG_DIR_Y:    dir_reg[1] <= cfg_wdata;
                rti_pkg::REG_DIR_Z:    dir_reg[2] <= cfg_wdata;
                rti_pkg::REG_EPSILON:  eps_reg <= cfg_wdata[rti_pkg::EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: vertices relative to the ray origin
    always_comb
    begin
        vtx[0][0] = a_x; vtx[0][1] = a_y; vtx[0][2] = a_z;
        vtx[1][0] = b_x; vtx[1][1] = b_y; vtx[1][2] = b_z;
        vtx[2][0] = c_x; vtx[2][1] = c_y; vtx[2][2] = c_z;
        for (int i = 0; i < 3; i++)
        begin
            for (int m = 0; m < 3; m++)
            begin
                a_next[i][m] = rti_pkg::A_W'(vtx[i][m]) - rti_pkg::A_W'(org_reg[m]);
            end
        end
    end

    // stage 2: cross product terms of a0 x a1, a1 x a2, a2 x a0
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int m = 0; m < 3; m++)
            begin
                pp_next[k][m][0] = a_reg[k][(m+1)%3] * a_reg[(k+1)%3][(m+2)%3];
                pp_next[k][m][1] = a_reg[k][(m+2)%3] * a_reg[(k+1)%3][(m+1)%3];
            end
        end
    end

    // stage 3: cross product components
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int m = 0; m < 3; m++)
            begin
                cr_next[k][m] = rti_pkg::CROSS_W'(pp_reg[k][m][0])
                              - rti_pkg::CROSS_W'(pp_reg[k][m][1]);
            end
        end
    end

    // stage 4: sliced products with the direction and with a0
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int m = 0; m < 3; m++)
            begin
                tp_next[k][m][0] = dir_reg[m]
                    * $signed({1'b0, cr_reg[k][m][rti_pkg::LO_W-1:0]});
                tp_next[k][m][1] = dir_reg[m]
                    * $signed(cr_reg[k][m][rti_pkg::CROSS_W-1:rti_pkg::LO_W]);
            end
        end
        for (int m = 0; m < 3; m++)
        begin
            np_next[m][0] = a0_s3_reg[m]
                * $signed({1'b0, cr_reg[1][m][rti_pkg::LO_W-1:0]});
            np_next[m][1] = a0_s3_reg[m]
                * $signed(cr_reg[1][m][rti_pkg::CROSS_W-1:rti_pkg::LO_W]);
        end
    end

    // stage 5: recombine slices per component
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int m = 0; m < 3; m++)
            begin
                tc_next[k][m] = (rti_pkg::DOT_W'(tp_reg[k][m][1]) <<< rti_pkg::LO_W)
                              + rti_pkg::DOT_W'(tp_reg[k][m][0]);
            end
        end
        for (int m = 0; m < 3; m++)
        begin
            nc_next[m] = (rti_pkg::DOT_W'(np_reg[m][1]) <<< rti_pkg::LO_W)
                       + rti_pkg::DOT_W'(np_reg[m][0]);
        end
    end

    // stage 6: triple products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t_next[k] = tc_reg[k][0] + tc_reg[k][1] + tc_reg[k][2];
        end
        num_next = nc_reg[0] + nc_reg[1] + nc_reg[2];
    end

    // stage 7: denominator is the sum of the per-edge products
    assign den_next = rti_pkg::DEN_W'(t_reg[0]) + rti_pkg::DEN_W'(t_reg[1])
                    + rti_pkg::DEN_W'(t_reg[2]);

    // stage 8: parallel, behind-origin and edge decisions, magnitudes for the divider
    always_comb
    begin
        logic                       dneg;
        logic [rti_pkg::DEN_W-1:0]  absden;
        logic [rti_pkg::DOT_W-1:0]  absnum;
        logic                       ok;
        dneg = den_reg[rti_pkg::DEN_W-1];
        absden = dneg ? rti_pkg::DEN_W'(-den_reg) : rti_pkg::DEN_W'(den_reg);
        absnum = num_s7_reg[rti_pkg::DOT_W-1] ? rti_pkg::DOT_W'(-num_s7_reg)
                                               : rti_pkg::DOT_W'(num_s7_reg);
        ok = (|den_reg)
             && (absden >= rti_pkg::DEN_W'({eps_reg, {(2*rti_pkg::FRAC_BITS){1'b0}}}))
             && !((|num_s7_reg) && (num_s7_reg[rti_pkg::DOT_W-1] != dneg));
        for (int k = 0; k < 3; k++)
        begin
            if (tnz_reg[k] && (tneg_reg[k] != dneg))
            begin
                ok = 1'b0;
            end
        end
        dv_next.hit = ok;
        dv_next.sat = 1'b0;
        dv_next.rem = {absnum, {rti_pkg::FRAC_BITS{1'b0}}};
        dv_next.den = absden;
        dv_next.quo = '0;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < rti_pkg::FRONT_STAGES; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int s = 1; s < rti_pkg::FRONT_STAGES; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
            done_reg <= div_out_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        a0_s2_reg <= a_reg[0];
        a0_s3_reg <= a0_s2_reg;
        pp_reg <= pp_next;
        cr_reg <= cr_next;
        tp_reg <= tp_next;
        np_reg <= np_next;
        tc_reg <= tc_next;
        nc_reg <= nc_next;
        t_reg <= t_next;
        num_reg <= num_next;
        den_reg <= den_next;
        num_s7_reg <= num_reg;
        for (int k = 0; k < 3; k++)
        begin
            tneg_reg[k] <= t_reg[k][rti_pkg::DOT_W-1];
            tnz_reg[k] <= |t_reg[k];
        end
        dv_reg <= dv_next;
        hit_reg <= div_out.hit;
        dist_reg <= dist_next;
    end

    // distance divider
    rti_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[rti_pkg::FRONT_STAGES-1]),
        .in_data   (dv_reg),
        .out_valid (div_out_valid),
        .out_data  (div_out)
    );

    // output select: zero on a miss, saturate when t does not fit
    assign dist_next = !div_out.hit ? '0
                     : (div_out.sat ? rti_pkg::DIST_MAX : div_out.quo);

    assign done = done_reg;
    assign hit = hit_reg;
    assign distance = dist_reg;

endmodule

// ----- sv/rti_check.sv -----
// rti_check: port-level checks for ray_triangle_intersect_core, bound into that module
// depends on rti_pkg
module rti_check (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       done,
    input  logic                       hit,
    input  logic [rti_pkg::DIST_W-1:0] distance
);

    // every accepted transaction returns after the fixed latency
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(rti_pkg::LATENCY) done)
        else $error("accepted triangle produced no result");

    // no result without a matching accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, rti_pkg::LATENCY))
        else $error("result without accepted triangle");

    // a miss reports zero distance
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !hit |-> distance == '0)
        else $error("nonzero distance on a miss");

endmodule

bind ray_triangle_intersect_core rti_check u_rti_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .hit      (hit),
    .distance (distance)
);

// ----- verif/tb.sv -----
// tb: self-checking testbench for ray_triangle_intersect_core
// depends on rti_pkg and the core; exact wide-integer predictor, random triangles and rays
`timescale 1ns / 1ps

module tb;

    localparam int ONE = 1 << rti_pkg::FRAC_BITS;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef logic signed [319:0] wide_t;
    typedef struct packed {
        wide_t x;
        wide_t y;
        wide_t z;
    } wvec_t;
    typedef struct packed {
        logic                       hit;
        logic [rti_pkg::DIST_W-1:0] t_dist;
    } hit_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [rti_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [rti_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic start = 1'b0;
    logic busy;
    rti_pkg::coord_t a_x = '0, a_y = '0, a_z = '0;
    rti_pkg::coord_t b_x = '0, b_y = '0, b_z = '0;
    rti_pkg::coord_t c_x = '0, c_y = '0, c_z = '0;
    logic done;
    logic hit;
    logic [rti_pkg::DIST_W-1:0] distance;

    // mirror of the ray registers
    logic [rti_pkg::CFG_W-1:0] ray_reg [0:6];
    hit_result_t expected_hits [$];
    int errors = 0;
    int idle_cycles = 0;
    bit no_gaps = 0;

    ray_triangle_intersect_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .start     (start),
        .busy      (busy),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .c_x       (c_x),
        .c_y       (c_y),
        .c_z       (c_z),
        .done      (done),
        .hit       (hit),
        .distance  (distance)
    );

    always #10 clk = ~clk;

    // exact vector helpers
    function automatic wvec_t mk(input rti_pkg::coord_t x, input rti_pkg::coord_t y,
                                 input rti_pkg::coord_t z);
        wvec_t v;
        v.x = x;
        v.y = y;
        v.z = z;
        return v;
    endfunction

    function automatic wvec_t vsub(input wvec_t p, input wvec_t q);
        wvec_t v;
        v.x = p.x - q.x;
        v.y = p.y - q.y;
        v.z = p.z - q.z;
        return v;
    endfunction

    function automatic wvec_t vcross(input wvec_t p, input wvec_t q);
        wvec_t v;
        v.x = p.y * q.z - p.z * q.y;
        v.y = p.z * q.x - p.x * q.z;
        v.z = p.x * q.y - p.y * q.x;
        return v;
    endfunction

    function automatic wide_t vdot(input wvec_t p, input wvec_t q);
        return p.x * q.x + p.y * q.y + p.z * q.z;
    endfunction

    function automatic int sgn(input wide_t w);
        return (w < 0) ? -1 : ((w == 0) ? 0 : 1);
    endfunction

    // false when the intersection lies outside edge e starting at base
    function automatic bit edge_inside(input wvec_t n, input wvec_t e, input wvec_t base,
                                       input wvec_t org, input wvec_t dir,
                                       input wide_t num, input wide_t den, input int sd);
        wide_t p, q, s;
        p = vdot(n, vcross(e, vsub(org, base)));
        q = vdot(n, vcross(e, dir));
        s = den * p + num * q;
        return sgn(s) != -sd;
    endfunction

    // expected hit and distance of one triangle against the current ray
    function automatic hit_result_t predict_hit(input rti_pkg::coord_t ax,
            input rti_pkg::coord_t ay, input rti_pkg::coord_t az,
            input rti_pkg::coord_t bx, input rti_pkg::coord_t by, input rti_pkg::coord_t bz,
            input rti_pkg::coord_t cx, input rti_pkg::coord_t cy, input rti_pkg::coord_t cz);
        hit_result_t r;
        wvec_t v0, v1, v2, org, dir, n;
        wide_t den, num, lim, an, ad, quo;
        int sd, sn;
        r = '0;
        v0 = mk(ax, ay, az);
        v1 = mk(bx, by, bz);
        v2 = mk(cx, cy, cz);
        org = mk(ray_reg[rti_pkg::REG_ORIGIN_X], ray_reg[rti_pkg::REG_ORIGIN_Y],
                 ray_reg[rti_pkg::REG_ORIGIN_Z]);
        dir = mk(ray_reg[rti_pkg::REG_DIR_X], ray_reg[rti_pkg::REG_DIR_Y],
                 ray_reg[rti_pkg::REG_DIR_Z]);
        n = vcross(vsub(v1, v0), vsub(v2, v0));
        den = vdot(n, dir);
        sd = sgn(den);
        lim = 0;
        lim[rti_pkg::EPS_W-1:0] = ray_reg[rti_pkg::REG_EPSILON][rti_pkg::EPS_W-1:0];
        lim = lim <<< (2 * rti_pkg::FRAC_BITS);
        ad = (sd < 0) ? -den : den;
        if (sd == 0 || ad < lim)
            return r;
        num = vdot(n, vsub(v0, org));
        sn = sgn(num);
        if (sn != 0 && sn != sd)
            return r;
        if (!edge_inside(n, vsub(v1, v0), v0, org, dir, num, den, sd) ||
            !edge_inside(n, vsub(v2, v1), v1, org, dir, num, den, sd) ||
            !edge_inside(n, vsub(v0, v2), v2, org, dir, num, den, sd))
            return r;
        an = (sn < 0) ? -num : num;
        quo = (an <<< rti_pkg::FRAC_BITS) / ad;
        r.hit = 1'b1;
        r.t_dist = (quo > wide_t'(rti_pkg::DIST_MAX)) ? rti_pkg::DIST_MAX
                                                      : quo[rti_pkg::DIST_W-1:0];
        return r;
    endfunction

    // append one expected result to the scoreboard queue
    function automatic void record_expected(input hit_result_t r);
        expected_hits.insert(expected_hits.size(), r);
    endfunction

    // one register write; the caller lowers the write enable after the last one
    task automatic write_reg(input rti_pkg::cfg_idx_t idx,
                             input logic [rti_pkg::CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        ray_reg[idx] = val;
    endtask

    task automatic set_ray(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                           input logic [31:0] dx, input logic [31:0] dy, input logic [31:0] dz,
                           input logic [31:0] eps);
        write_reg(rti_pkg::REG_ORIGIN_X, ox);
        write_reg(rti_pkg::REG_ORIGIN_Y, oy);
        write_reg(rti_pkg::REG_ORIGIN_Z, oz);
        write_reg(rti_pkg::REG_DIR_X, dx);
        write_reg(rti_pkg::REG_DIR_Y, dy);
        write_reg(rti_pkg::REG_DIR_Z, dz);
        write_reg(rti_pkg::REG_EPSILON, eps);
        cfg_we <= 1'b0;
    endtask

    // wait until every expected result is back, then let the pipeline settle
    task automatic drain();
        start <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (rti_pkg::LATENCY + 4) @(posedge clk);
    endtask

    // send one triangle after a random gap (none when no_gaps is set) and record its expected result
    task automatic send_triangle(input rti_pkg::coord_t ax, input rti_pkg::coord_t ay,
                                 input rti_pkg::coord_t az, input rti_pkg::coord_t bx,
                                 input rti_pkg::coord_t by, input rti_pkg::coord_t bz,
                                 input rti_pkg::coord_t cx, input rti_pkg::coord_t cy,
                                 input rti_pkg::coord_t cz);
        int gap;
        bit accepted;
        int sel;
        sel = $urandom_range(0, 99);
        gap = no_gaps ? 0 : (sel < 50) ? 0 : (sel < 90) ? $urandom_range(1, 3)
                                                        : $urandom_range(10, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        a_x <= ax; a_y <= ay; a_z <= az;
        b_x <= bx; b_y <= by; b_z <= bz;
        c_x <= cx; c_y <= cy; c_z <= cz;
        accepted = 0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = !busy;
            @(posedge clk);
        end
        record_expected(predict_hit(ax, ay, az, bx, by, bz, cx, cy, cz));
    endtask

    // random triangle, mostly placed around a point on the ray line
    task automatic send_random_triangle();
        longint px, py, pz, k, span;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            send_triangle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom);
        end
        else
        begin
            k = (sel < 30) ? -longint'($urandom_range(0, 64)) : longint'($urandom_range(0, 64));
            px = longint'($signed(ray_reg[rti_pkg::REG_ORIGIN_X]))
               + k * longint'($signed(ray_reg[rti_pkg::REG_DIR_X]));
            py = longint'($signed(ray_reg[rti_pkg::REG_ORIGIN_Y]))
               + k * longint'($signed(ray_reg[rti_pkg::REG_DIR_Y]));
            pz = longint'($signed(ray_reg[rti_pkg::REG_ORIGIN_Z]))
               + k * longint'($signed(ray_reg[rti_pkg::REG_DIR_Z]));
            span = longint'(1) << $urandom_range(4, 22);
            send_triangle(rti_pkg::coord_t'(px + $urandom_range(0, span) - span / 2),
                          rti_pkg::coord_t'(py - $urandom_range(0, span)),
                          rti_pkg::coord_t'(pz + $urandom_range(0, span) - span / 2),
                          rti_pkg::coord_t'(px + $urandom_range(0, span)),
                          rti_pkg::coord_t'(py + $urandom_range(0, span)),
                          rti_pkg::coord_t'(pz + $urandom_range(0, span) - span / 2),
                          rti_pkg::coord_t'(px - $urandom_range(0, span)),
                          rti_pkg::coord_t'(py + $urandom_range(0, span) - span / 2),
                          rti_pkg::coord_t'(pz + $urandom_range(0, span) - span / 2));
        end
    endtask

    function automatic logic [31:0] small_val(input int bits);
        return 32'($signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
    endfunction

    // directed cases against a ray along +z from the origin
    task automatic test_directed();
        set_ray(0, 0, 0, 0, 0, ONE, 66);
        send_triangle(-ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE);
        send_triangle(0, -ONE, 3*ONE, 0, 2*ONE, 3*ONE, -2*ONE, 0, 3*ONE);
        send_triangle(0, 0, 2*ONE, ONE, 0, 2*ONE, 0, ONE, 2*ONE);
        send_triangle(-ONE, -ONE, 0, 2*ONE, -ONE, 0, -ONE, 2*ONE, 0);
        send_triangle(-ONE, -ONE, -5*ONE, 2*ONE, -ONE, -5*ONE, -ONE, 2*ONE, -5*ONE);
        send_triangle(ONE, ONE, 4*ONE, 3*ONE, ONE, 4*ONE, ONE, 3*ONE, 4*ONE);
        send_triangle(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
        send_triangle(0, 0, 0, ONE, 0, 0, 0, 0, ONE);
        send_triangle(ONE, 0, 3*ONE, -ONE, 0, 3*ONE, 0, 0, 4*ONE);
        send_triangle(32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                      32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                      32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_triangle(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                      32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                      32'h7FFFFFFF, 32'h80000000, 32'h80000000);
        send_triangle(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h80000000, 32'h7FFFFFFF, 0);
        drain();
        // tiny direction so t saturates
        set_ray(0, 0, 0, 0, 0, 1, 0);
        send_triangle(-ONE, -ONE, 32'h40000000, 2*ONE, -ONE, 32'h40000000,
                      -ONE, 2*ONE, 32'h40000000);
        send_triangle(-ONE, -ONE, ONE, 2*ONE, -ONE, ONE, -ONE, 2*ONE, ONE);
        drain();
        // largest epsilon rejects nearly everything
        set_ray(0, 0, 0, 0, 0, ONE, 32'h7FFFFFFF);
        send_triangle(-ONE, -ONE, 5*ONE, 2*ONE, -ONE, 5*ONE, -ONE, 2*ONE, 5*ONE);
        send_triangle(32'h80000000, 32'h80000000, ONE, 32'h7FFFFFFF, 32'h80000000, ONE,
                      32'h80000000, 32'h7FFFFFFF, ONE);
        drain();
    endtask

    // random triangles under one ray setting
    task automatic test_random_ray(input logic [31:0] ox, input logic [31:0] oy,
                                   input logic [31:0] oz, input logic [31:0] dx,
                                   input logic [31:0] dy, input logic [31:0] dz,
                                   input logic [31:0] eps, input int count);
        set_ray(ox, oy, oz, dx, dy, dz, eps);
        no_gaps = ($urandom_range(0, 2) == 0);
        repeat (count) send_random_triangle();
        drain();
        no_gaps = 0;
    endtask

    // sender pauses mid-run until all results are back
    task automatic test_pause();
        set_ray(small_val(20), small_val(20), small_val(20),
                small_val(17), small_val(17), small_val(17), 66);
        repeat (30) send_random_triangle();
        drain();
        repeat (30) send_random_triangle();
        drain();
    endtask

    // result checker, sampled mid-cycle
    always @(negedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected transaction hit=%0b distance=%0h", $realtime,
                         hit, distance);
                errors++;
            end
            else
            begin
                hit_result_t want;
                want = expected_hits.pop_front();
                if (hit !== want.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $realtime, want.hit, hit);
                    errors++;
                end
                if (distance !== want.t_dist)
                begin
                    $display("%0t: distance expected %0h actual %0h", $realtime,
                             want.t_dist, distance);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction either way
    always @(negedge clk)
    begin
        if (done || (start && !busy))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[ray_triangle_intersect_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        ray_reg[0] = 0; ray_reg[1] = 0; ray_reg[2] = 0;
        ray_reg[3] = 0; ray_reg[4] = 0; ray_reg[5] = 0;
        ray_reg[6] = 66;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // reset ray has zero direction: every triangle misses
        repeat (10) send_random_triangle();
        drain();
        test_directed();
        test_random_ray(small_val(20), small_val(20), small_val(20),
                        small_val(17), small_val(17), small_val(17), 66, 120);
        test_random_ray(small_val(24), small_val(24), small_val(24),
                        small_val(12), small_val(12), small_val(12), 0, 100);
        test_random_ray(small_val(16), small_val(16), small_val(16),
                        small_val(17), small_val(17), small_val(17),
                        $urandom_range(0, 32'h7FFFFFFF), 80);
        test_pause();
        test_random_ray(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                        32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 60);
        test_random_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, 60);
        test_random_ray(small_val(20), small_val(20), small_val(20), 1, 0, 1, 0, 60);
        if (errors == 0)
            $display("[ray_triangle_intersect_core] OK");
        else
            $display("[ray_triangle_intersect_core] ERROR");
        $finish;
    end

endmodule
